// ----- src/sei_pkg.sv -----
// ----------------------------------------------------------------------------
// sei_pkg
// Shared types and constants for the SEI message byte parser.
// ----------------------------------------------------------------------------
package sei_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 16;

  localparam logic [15:0] USER_TYPE_RST = 16'd5;
  localparam logic [15:0] DIGEST_TYPE_RST = 16'd256;
  localparam logic [7:0] MD5_METHOD_RST = 8'd0;

  localparam logic [7:0] HDR_EXT_BYTE = 8'hFF;
  localparam int unsigned UUID_BYTES = 16;
  localparam int unsigned DIGEST_MIN_SIZE = 17;
  localparam logic [15:0] LAST_FIELD_IDX = 16'd15;
  localparam logic [15:0] IDX_MAX = 16'hFFFF;

  // configuration register indexes
  localparam logic [1:0] CFG_USER_TYPE = 2'd0;
  localparam logic [1:0] CFG_DIGEST_TYPE = 2'd1;
  localparam logic [1:0] CFG_MD5_METHOD = 2'd2;

  // byte kinds
  localparam logic [2:0] KIND_TYPE = 3'd0;
  localparam logic [2:0] KIND_SIZE = 3'd1;
  localparam logic [2:0] KIND_UUID = 3'd2;
  localparam logic [2:0] KIND_USER = 3'd3;
  localparam logic [2:0] KIND_METHOD = 3'd4;
  localparam logic [2:0] KIND_DIGEST = 3'd5;
  localparam logic [2:0] KIND_SKIP = 3'd6;

  // error codes
  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN_TYPE = 3'd1;
  localparam logic [2:0] ERR_TOO_SHORT = 3'd2;
  localparam logic [2:0] ERR_BAD_METHOD = 3'd3;
  localparam logic [2:0] ERR_HDR_OVERFLOW = 3'd4;

  typedef enum logic [6:0] {
    PH_TYPE   = 7'b0000001,
    PH_SIZE   = 7'b0000010,
    PH_UUID   = 7'b0000100,
    PH_USER   = 7'b0001000,
    PH_METHOD = 7'b0010000,
    PH_DIGEST = 7'b0100000,
    PH_SKIP   = 7'b1000000
  } phase_t;

endpackage

// ----- src/sei_message_byte_parser.sv -----
// ----------------------------------------------------------------------------
// sei_message_byte_parser
// Labels each byte of an SEI message: header sums, uuid, user data, digest
// method, digest and skipped bytes, with error flags and an end-of-message mark.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one message byte per word (valid/ready).
//   out_* : one labelled result word per input byte (valid/ready), carrying
//           kind, index in field, running type and size, latched error and
//           the end-of-message mark.
//   cfg_* : register writes (valid/ready, always ready); index 0 user data
//           type, 1 digest type, 2 accepted digest method. Write while idle.
// Throughput is one byte per cycle while the receiver does not stall. A byte
// passes an input register, then the phase and counter update writes the
// result register.
// When the receiver stalls, the result register holds and the input
// register takes one more byte, after which in_ready drops.
// Reset empties both registers, restores the register defaults and puts the
// parser at the start of a message. State also returns to that point after
// every word marked message_end.
// ----------------------------------------------------------------------------
module sei_message_byte_parser #(
  parameter int unsigned LENGTH_BITS = sei_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte_value,
  output logic [2:0]  out_byte_kind,
  output logic [15:0] out_field_index,
  output logic [15:0] out_payload_type,
  output logic [15:0] out_payload_size,
  output logic [2:0]  out_error_code,
  output logic        out_message_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned W = LENGTH_BITS;
  localparam int unsigned CW = (W > 16) ? W : 16;
  localparam logic [W-1:0] SUM_MAX = {W{1'b1}};

  logic [15:0] cfg_user_r, cfg_digest_r;
  logic [7:0]  cfg_md5_r;

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        adv;

  sei_pkg::phase_t phase_r, phase_nxt;
  logic [W-1:0] type_sum_r, type_sum_nxt;
  logic [W-1:0] size_sum_r, size_sum_nxt;
  logic [W-1:0] pos_r, pos_nxt;
  logic [15:0]  cnt_r, cnt_nxt;
  logic [2:0]   err_r, err_nxt;
  logic         end_nxt;
  logic [2:0]   kind_nxt;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic [2:0]  out_kind_r;
  logic [15:0] out_idx_r;
  logic [15:0] out_type_r;
  logic [15:0] out_size_r;
  logic [2:0]  out_err_r;
  logic        out_end_r;

  assign cfg_ready = 1'b1;
  assign adv = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_user_r   <= sei_pkg::USER_TYPE_RST;
      cfg_digest_r <= sei_pkg::DIGEST_TYPE_RST;
      cfg_md5_r    <= sei_pkg::MD5_METHOD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sei_pkg::CFG_USER_TYPE:   cfg_user_r <= cfg_data;
        sei_pkg::CFG_DIGEST_TYPE: cfg_digest_r <= cfg_data;
        sei_pkg::CFG_MD5_METHOD:  cfg_md5_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [W:0]   add_v;
    logic [W-1:0] sum_v;
    logic [2:0]   err_v;
    logic [15:0]  cnt_inc;
    logic         is_user;
    logic         is_known;
    phase_nxt    = phase_r;
    type_sum_nxt = type_sum_r;
    size_sum_nxt = size_sum_r;
    pos_nxt      = pos_r;
    err_v        = err_r;
    end_nxt      = 1'b0;
    cnt_inc      = (cnt_r != sei_pkg::IDX_MAX) ? cnt_r + 16'd1 : cnt_r;
    cnt_nxt      = cnt_inc;
    add_v        = {1'b0, (phase_r == sei_pkg::PH_TYPE) ? type_sum_r : size_sum_r}
                   + (W+1)'(in_byte_r);
    sum_v        = add_v[W-1:0];
    if (add_v[W]) begin
      sum_v = SUM_MAX;
    end
    is_user  = CW'(type_sum_r) == CW'(cfg_user_r);
    is_known = (CW'(sum_v) == CW'(cfg_user_r)) || (CW'(sum_v) == CW'(cfg_digest_r));
    unique case (phase_r) inside
      sei_pkg::PH_TYPE: begin
        if (add_v[W] && err_v == sei_pkg::ERR_NONE) err_v = sei_pkg::ERR_HDR_OVERFLOW;
        type_sum_nxt = sum_v;
        if (in_byte_r != sei_pkg::HDR_EXT_BYTE) begin
          phase_nxt = sei_pkg::PH_SIZE;
          cnt_nxt   = '0;
          if (!is_known && err_v == sei_pkg::ERR_NONE) err_v = sei_pkg::ERR_UNKNOWN_TYPE;
        end
      end
      sei_pkg::PH_SIZE: begin
        if (add_v[W] && err_v == sei_pkg::ERR_NONE) err_v = sei_pkg::ERR_HDR_OVERFLOW;
        size_sum_nxt = sum_v;
        if (in_byte_r != sei_pkg::HDR_EXT_BYTE) begin
          cnt_nxt = '0;
          if (err_v != sei_pkg::ERR_NONE) begin
            phase_nxt = sei_pkg::PH_SKIP;
          end else if (is_user) begin
            if (sum_v < W'(sei_pkg::UUID_BYTES)) begin
              err_v     = sei_pkg::ERR_TOO_SHORT;
              phase_nxt = sei_pkg::PH_SKIP;
            end else begin
              phase_nxt = sei_pkg::PH_UUID;
            end
          end else begin
            if (sum_v < W'(sei_pkg::DIGEST_MIN_SIZE)) begin
              err_v     = sei_pkg::ERR_TOO_SHORT;
              phase_nxt = sei_pkg::PH_SKIP;
            end else begin
              phase_nxt = sei_pkg::PH_METHOD;
            end
          end
          end_nxt = (sum_v == '0);
        end
      end
      sei_pkg::PH_UUID, sei_pkg::PH_DIGEST: begin
        pos_nxt = pos_r + W'(1);
        if (cnt_r == sei_pkg::LAST_FIELD_IDX) begin
          phase_nxt = (phase_r == sei_pkg::PH_UUID) ? sei_pkg::PH_USER : sei_pkg::PH_SKIP;
          cnt_nxt   = '0;
        end
        end_nxt = (pos_nxt >= size_sum_r);
      end
      sei_pkg::PH_METHOD: begin
        pos_nxt = pos_r + W'(1);
        if (in_byte_r != cfg_md5_r && err_v == sei_pkg::ERR_NONE) begin
          err_v = sei_pkg::ERR_BAD_METHOD;
        end
        phase_nxt = sei_pkg::PH_DIGEST;
        cnt_nxt   = '0;
        end_nxt   = (pos_nxt >= size_sum_r);
      end
      default: begin
        pos_nxt = pos_r + W'(1);
        end_nxt = (pos_nxt >= size_sum_r);
      end
    endcase
    err_nxt = err_v;
  end

  always_comb begin
    unique case (phase_r)
      sei_pkg::PH_TYPE:   kind_nxt = sei_pkg::KIND_TYPE;
      sei_pkg::PH_SIZE:   kind_nxt = sei_pkg::KIND_SIZE;
      sei_pkg::PH_UUID:   kind_nxt = sei_pkg::KIND_UUID;
      sei_pkg::PH_USER:   kind_nxt = sei_pkg::KIND_USER;
      sei_pkg::PH_METHOD: kind_nxt = sei_pkg::KIND_METHOD;
      sei_pkg::PH_DIGEST: kind_nxt = sei_pkg::KIND_DIGEST;
      default:            kind_nxt = sei_pkg::KIND_SKIP;
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_data_byte;
    end
  end

  // message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= sei_pkg::PH_TYPE;
      type_sum_r <= '0;
      size_sum_r <= '0;
      pos_r      <= '0;
      cnt_r      <= '0;
      err_r      <= sei_pkg::ERR_NONE;
    end else if (adv) begin
      if (end_nxt) begin
        phase_r    <= sei_pkg::PH_TYPE;
        type_sum_r <= '0;
        size_sum_r <= '0;
        pos_r      <= '0;
        cnt_r      <= '0;
        err_r      <= sei_pkg::ERR_NONE;
      end else begin
        phase_r    <= phase_nxt;
        type_sum_r <= type_sum_nxt;
        size_sum_r <= size_sum_nxt;
        pos_r      <= pos_nxt;
        cnt_r      <= cnt_nxt;
        err_r      <= err_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= in_byte_r;
      out_kind_r <= kind_nxt;
      out_idx_r  <= cnt_r;
      out_type_r <= 16'(type_sum_nxt);
      out_size_r <= 16'(size_sum_nxt);
      out_err_r  <= err_nxt;
      out_end_r  <= end_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte_value   = out_byte_r;
  assign out_byte_kind    = out_kind_r;
  assign out_field_index  = out_idx_r;
  assign out_payload_type = out_type_r;
  assign out_payload_size = out_size_r;
  assign out_error_code   = out_err_r;
  assign out_message_end  = out_end_r;

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && end_nxt |=> phase_r == sei_pkg::PH_TYPE && type_sum_r == '0 && err_r == '0)
    else $error("state not cleared after message end");

  a_payload_size: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != sei_pkg::PH_TYPE && phase_r != sei_pkg::PH_SIZE |-> size_sum_r != '0)
    else $error("payload phase with empty size");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    adv && err_r != sei_pkg::ERR_NONE && !end_nxt |=> err_r == $past(err_r))
    else $error("latched error changed within a message");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !adv |=> in_valid_r && $stable(in_byte_r))
    else $error("input register lost a word");

endmodule
